[design/polygon_miter_offset_macros.svh]
// Assertion helpers used by the controller (pmo_ctrl).
`ifndef POLYGON_MITER_OFFSET_MACROS_SVH
`define POLYGON_MITER_OFFSET_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PMO_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pmo_pkg.sv]
package pmo_pkg;

  localparam int COORD_W   = 24;
  localparam int HEIGHT_W  = 24;
  localparam int OVH_W     = 16;
  localparam int IDX_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 24;
  localparam int VEC_W     = 25;   // edge difference or normal sum
  localparam int MAG_W     = 24;
  localparam int SQ_W      = 49;
  localparam int RAD_W     = 64;   // square root operand
  localparam int LEN_W     = 32;
  localparam int NUM_W     = 47;   // divider dividend
  localparam int QUO_W     = 18;   // divider quotient bits
  localparam int CNT_W     = 5;
  localparam int UNIT_W    = 17;   // Q1.15 plus sign
  localparam int DOT_W     = 34;
  localparam int COS_W     = 17;
  localparam int SCALE_W   = 18;
  localparam int M1_W      = 36;
  localparam int M2_W      = 53;

  localparam int SQ_SHIFT   = 14;
  localparam int NUM_SHIFT  = 22;
  localparam int COS_SHIFT  = 15;
  localparam int PUSH_SHIFT = 30;
  localparam int Q15_ONE    = 32768;
  localparam int COS_FLOOR  = 8192;
  localparam int SCALE_MAX  = 131072;
  localparam int NEAR_ZERO  = 4;
  localparam int COORD_MAX  = 8388607;
  localparam int COORD_MIN  = -8388608;

  localparam logic [CFG_IDX_W-1:0] REG_OVERHANG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 1'd1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;

  typedef struct packed {
    coord_t vx;
    coord_t vy;
    logic   final_vertex;
  } in_item_t;

  typedef struct packed {
    coord_t             ox;
    coord_t             oy;
    coord_t             oz;
    logic [IDX_W-1:0]   vertex_index;
    logic               run_end;
  } out_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PLAN, S_UV_LD, S_UV_SQ, S_SQ_GO, S_SQ_WAIT,
    S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT, S_SUM,
    S_DOT1, S_DOT2, S_SC_GO, S_SC_WAIT,
    S_MUL1, S_MUL2, S_PUSH, S_EMIT, S_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    J_NONE, J_PASS_CUR, J_PASS_FIRST, J_OFF_A, J_OFF_B, J_OFF_C
  } job_t;

  typedef enum logic [1:0] {UV_IN, UV_OUT, UV_BIS} uv_t;
  typedef enum logic [1:0] {CNT_ZERO, CNT_ONE, CNT_MANY} cnt_case_t;
  typedef enum logic [1:0] {DIV_X, DIV_Y, DIV_SCALE} div_op_t;

  typedef struct packed {
    logic    accept;
    logic    uv_load;
    logic    sq_load;
    logic    uv_zero;
    logic    sqrt_start;
    logic    div_start;
    logic    store_qx;
    logic    store_qy;
    logic    bis_fallback;
    logic    dot_load;
    logic    cos_load;
    logic    scale_store;
    logic    mul1;
    logic    mul2;
    logic    push;
    logic    out_load;
    logic    finish;
    div_op_t div_op;
    job_t    job;
    uv_t     uv;
  } dp_cmd_t;

  typedef struct packed {
    cnt_case_t cnt_case;
    logic      fin;
    logic      vec_zero;
    logic      near_zero;
    logic      sqrt_busy;
    logic      div_busy;
    logic      out_free;
  } dp_sts_t;

endpackage

[design/pmo_sqrt.sv]
module pmo_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pmo_pkg::RAD_W-1:0]   operand,
  output logic                        busy,
  output logic [pmo_pkg::LEN_W-1:0]   root
);
  localparam int RW = pmo_pkg::RAD_W;

  logic [RW-1:0] n_r, n_nxt;
  logic [RW-1:0] res_r, res_nxt;
  logic [RW-1:0] bit_r, bit_nxt;
  logic [RW-1:0] trial;

  assign trial = res_r + bit_r;

  // One result bit per cycle, two radicand bits per step.
  always_comb begin
    n_nxt   = n_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    if (start) begin
      n_nxt   = operand;
      res_nxt = '0;
      bit_nxt = RW'(1) << (RW - 2);
    end else if (bit_r != '0) begin
      if (n_r >= trial) begin
        n_nxt   = n_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else begin
      bit_r <= bit_nxt;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
  end

  assign busy = (bit_r != '0);
  assign root = res_r[pmo_pkg::LEN_W-1:0];

endmodule

[design/pmo_div.sv]
module pmo_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pmo_pkg::NUM_W-1:0]   num,
  input  logic [pmo_pkg::LEN_W-1:0]   den,
  output logic                        busy,
  output logic [pmo_pkg::QUO_W-1:0]   quo
);
  localparam int NW = pmo_pkg::NUM_W;
  localparam int DW = pmo_pkg::LEN_W;
  localparam int QW = pmo_pkg::QUO_W;
  localparam int CW = pmo_pkg::CNT_W;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [QW-1:0] nsh_r, nsh_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   trial;

  // Restoring division; the quotient is known to fit in QW bits.
  assign trial = {rem_r, nsh_r[QW-1]};

  always_comb begin
    rem_nxt = rem_r;
    den_nxt = den_r;
    nsh_nxt = nsh_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = DW'(num[NW-1:QW]);
      den_nxt = den;
      nsh_nxt = num[QW-1:0];
      q_nxt   = '0;
      cnt_nxt = CW'(QW);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DW'(trial - {1'b0, den_r});
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      nsh_nxt = nsh_r << 1;
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    nsh_r <= nsh_nxt;
    q_r   <= q_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = q_r;

endmodule

[design/pmo_dp.sv]
module pmo_dp #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pmo_pkg::dp_cmd_t              cmd,
  output pmo_pkg::dp_sts_t              sts,
  input  pmo_pkg::in_item_t             in_data,
  input  logic [pmo_pkg::OVH_W-1:0]     overhang,
  input  pmo_pkg::coord_t               height,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pmo_pkg::out_item_t            out_data
);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int IW  = pmo_pkg::IDX_W;
  localparam int VW  = pmo_pkg::VEC_W;
  localparam int MW  = pmo_pkg::MAG_W;
  localparam int NW  = pmo_pkg::NUM_W;
  localparam int LW  = pmo_pkg::LEN_W;
  localparam int UW  = pmo_pkg::UNIT_W;
  localparam int SW  = pmo_pkg::SCALE_W;
  localparam int M1W = pmo_pkg::M1_W;
  localparam int M2W = pmo_pkg::M2_W;
  localparam int PW  = pmo_pkg::COORD_W + 2;

  pmo_pkg::point_t first_r, second_r, older_r, newer_r, cur_r, res_r;
  logic            fin_r;
  logic [CW-1:0]   count_r;

  logic signed [VW-1:0] vx_r, vy_r;
  logic [MW-1:0]        mx_r, my_r;
  logic [pmo_pkg::SQ_W-1:0] sq_r;
  pmo_pkg::unit_t       inx_r, iny_r, outx_r, outy_r, bx_r, by_r;
  logic                 in_ok_r, out_ok_r;
  logic signed [pmo_pkg::DOT_W-1:0] px_r, py_r;
  logic [pmo_pkg::COS_W-1:0] c_r;
  logic [SW-1:0]        scale_r;
  logic signed [M1W-1:0] m1x_r, m1y_r;
  logic signed [M2W-1:0] m2x_r, m2y_r;
  logic                 out_valid_r;
  pmo_pkg::out_item_t   out_data_r;

  pmo_pkg::point_t      pp, pc, pn;
  logic signed [VW-1:0] sel_x, sel_y, sum_x, sum_y;
  logic                 sqrt_busy, div_busy;
  logic [LW-1:0]        root;
  logic [NW-1:0]        div_num;
  logic [LW-1:0]        div_den;
  logic [SW-1:0]        quo;
  logic [15:0]          qclamp;
  pmo_pkg::unit_t       unit_q;
  logic signed [pmo_pkg::DOT_W:0] dot_sum;
  logic [pmo_pkg::DOT_W:0] dot_mag;
  logic [pmo_pkg::COS_W-1:0] cos_rnd;
  logic [IW-1:0]        idx_c;
  pmo_pkg::coord_t      emit_x, emit_y;
  logic                 out_free;

  function automatic logic [MW-1:0] mag_of(input logic signed [VW-1:0] v);
    logic [VW-1:0] a;
    a = (v < 0) ? VW'(-v) : VW'(v);
    return a[MW-1:0];
  endfunction

  function automatic logic [IW-1:0] idx_of(input logic [CW-1:0] k);
    logic [CW-1:0] m;
    m = (k > CW'(MAX_VERTICES - 1)) ? CW'(MAX_VERTICES - 1) : k;
    return IW'(m);
  endfunction

  // Round half away from zero by PUSH_SHIFT, add to the coordinate, saturate.
  function automatic pmo_pkg::coord_t push_axis(input pmo_pkg::coord_t base,
                                                input logic signed [M2W-1:0] v);
    logic [M2W-1:0]       m;
    logic [M2W-1:0]       r;
    logic signed [PW-1:0] s;
    m = (v < 0) ? M2W'(-v) : M2W'(v);
    r = (m + (M2W'(1) << (pmo_pkg::PUSH_SHIFT - 1))) >> pmo_pkg::PUSH_SHIFT;
    s = (v < 0) ? (PW'(base) - $signed(PW'(r))) : (PW'(base) + $signed(PW'(r)));
    if (s > PW'(pmo_pkg::COORD_MAX)) begin
      return pmo_pkg::coord_t'(pmo_pkg::COORD_MAX);
    end else if (s < PW'(pmo_pkg::COORD_MIN)) begin
      return pmo_pkg::coord_t'(pmo_pkg::COORD_MIN);
    end
    return s[pmo_pkg::COORD_W-1:0];
  endfunction

  // Vertex triple of the current job.
  always_comb begin
    case (cmd.job)
      pmo_pkg::J_OFF_B: begin
        pp = newer_r; pc = cur_r;   pn = first_r;
      end
      pmo_pkg::J_OFF_C: begin
        pp = cur_r;   pc = first_r; pn = second_r;
      end
      default: begin
        pp = older_r; pc = newer_r; pn = cur_r;
      end
    endcase
  end

  assign sum_x = VW'(inx_r) + VW'(outx_r);
  assign sum_y = VW'(iny_r) + VW'(outy_r);

  always_comb begin
    case (cmd.uv)
      pmo_pkg::UV_IN: begin
        sel_x = VW'(pc.y) - VW'(pp.y);
        sel_y = VW'(pp.x) - VW'(pc.x);
      end
      pmo_pkg::UV_OUT: begin
        sel_x = VW'(pn.y) - VW'(pc.y);
        sel_y = VW'(pc.x) - VW'(pn.x);
      end
      default: begin
        sel_x = sum_x;
        sel_y = sum_y;
      end
    endcase
  end

  always_comb begin
    case (cmd.div_op)
      pmo_pkg::DIV_X: begin
        div_num = (NW'(mx_r) << pmo_pkg::NUM_SHIFT) + NW'(root >> 1);
        div_den = root;
      end
      pmo_pkg::DIV_Y: begin
        div_num = (NW'(my_r) << pmo_pkg::NUM_SHIFT) + NW'(root >> 1);
        div_den = root;
      end
      default: begin
        div_num = (NW'(1) << pmo_pkg::PUSH_SHIFT) + NW'(c_r >> 1);
        div_den = LW'(c_r);
      end
    endcase
  end

  pmo_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sqrt_start),
    .operand (pmo_pkg::RAD_W'(sq_r) << pmo_pkg::SQ_SHIFT),
    .busy    (sqrt_busy),
    .root    (root)
  );

  pmo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Clamp the quotient to one and restore the sign of the active component.
  always_comb begin
    qclamp = (quo > SW'(pmo_pkg::Q15_ONE)) ? 16'(pmo_pkg::Q15_ONE) : quo[15:0];
    if (cmd.store_qx ? (vx_r < 0) : (vy_r < 0)) begin
      unit_q = -$signed(UW'(qclamp));
    end else begin
      unit_q = $signed(UW'(qclamp));
    end
  end

  always_comb begin
    dot_sum = (pmo_pkg::DOT_W + 1)'(px_r) + (pmo_pkg::DOT_W + 1)'(py_r);
    dot_mag = (dot_sum < 0) ? (pmo_pkg::DOT_W + 1)'(-dot_sum)
                            : (pmo_pkg::DOT_W + 1)'(dot_sum);
    dot_mag = (dot_mag + ((pmo_pkg::DOT_W + 1)'(1) << (pmo_pkg::COS_SHIFT - 1)))
              >> pmo_pkg::COS_SHIFT;
    cos_rnd = dot_mag[pmo_pkg::COS_W-1:0];
  end

  always_comb begin
    case (cmd.job)
      pmo_pkg::J_PASS_CUR: idx_c = idx_of(count_r);
      pmo_pkg::J_OFF_A:    idx_c = idx_of(count_r - CW'(1));
      pmo_pkg::J_OFF_B:    idx_c = idx_of(count_r);
      default:             idx_c = '0;
    endcase
    case (cmd.job)
      pmo_pkg::J_PASS_CUR: begin
        emit_x = cur_r.x; emit_y = cur_r.y;
      end
      pmo_pkg::J_PASS_FIRST: begin
        emit_x = first_r.x; emit_y = first_r.y;
      end
      default: begin
        emit_x = res_r.x; emit_y = res_r.y;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) begin
        if (fin_r) begin
          count_r <= '0;
        end else if (count_r < CW'(MAX_VERTICES)) begin
          count_r <= count_r + CW'(1);
        end
      end
    end

    if (cmd.accept) begin
      cur_r.x <= in_data.vx;
      cur_r.y <= in_data.vy;
      fin_r   <= in_data.final_vertex;
    end

    if (cmd.finish) begin
      case (sts.cnt_case)
        pmo_pkg::CNT_ZERO: first_r <= cur_r;
        pmo_pkg::CNT_ONE: begin
          second_r <= cur_r;
          older_r  <= first_r;
          newer_r  <= cur_r;
        end
        default: begin
          if (!fin_r) begin
            older_r <= newer_r;
            newer_r <= cur_r;
          end
        end
      endcase
    end

    if (cmd.uv_load) begin
      vx_r <= sel_x;
      vy_r <= sel_y;
      mx_r <= mag_of(sel_x);
      my_r <= mag_of(sel_y);
    end
    if (cmd.sq_load) begin
      sq_r <= pmo_pkg::SQ_W'(mx_r) * pmo_pkg::SQ_W'(mx_r)
            + pmo_pkg::SQ_W'(my_r) * pmo_pkg::SQ_W'(my_r);
    end

    // Zero-length edge: zero normal, marked not valid.
    if (cmd.uv_zero) begin
      case (cmd.uv)
        pmo_pkg::UV_IN: begin
          inx_r <= '0; iny_r <= '0; in_ok_r <= 1'b0;
        end
        pmo_pkg::UV_OUT: begin
          outx_r <= '0; outy_r <= '0; out_ok_r <= 1'b0;
        end
        default: begin
          bx_r <= '0; by_r <= '0;
        end
      endcase
    end
    if (cmd.store_qx) begin
      case (cmd.uv)
        pmo_pkg::UV_IN:  inx_r  <= unit_q;
        pmo_pkg::UV_OUT: outx_r <= unit_q;
        default:         bx_r   <= unit_q;
      endcase
    end
    if (cmd.store_qy) begin
      case (cmd.uv)
        pmo_pkg::UV_IN: begin
          iny_r <= unit_q; in_ok_r <= 1'b1;
        end
        pmo_pkg::UV_OUT: begin
          outy_r <= unit_q; out_ok_r <= 1'b1;
        end
        default: by_r <= unit_q;
      endcase
    end

    // Vanishing bisector: unit scale along whichever normal is valid.
    if (cmd.bis_fallback) begin
      scale_r <= SW'(pmo_pkg::Q15_ONE);
      bx_r    <= in_ok_r ? inx_r : outx_r;
      by_r    <= in_ok_r ? iny_r : outy_r;
    end

    if (cmd.dot_load) begin
      px_r <= pmo_pkg::DOT_W'(bx_r) * pmo_pkg::DOT_W'(inx_r);
      py_r <= pmo_pkg::DOT_W'(by_r) * pmo_pkg::DOT_W'(iny_r);
    end
    if (cmd.cos_load) begin
      if (dot_sum < 0 || cos_rnd < pmo_pkg::COS_W'(pmo_pkg::COS_FLOOR)) begin
        c_r <= pmo_pkg::COS_W'(pmo_pkg::COS_FLOOR);
      end else begin
        c_r <= cos_rnd;
      end
    end
    if (cmd.scale_store) begin
      if (quo < SW'(pmo_pkg::Q15_ONE)) begin
        scale_r <= SW'(pmo_pkg::Q15_ONE);
      end else if (quo > SW'(pmo_pkg::SCALE_MAX)) begin
        scale_r <= SW'(pmo_pkg::SCALE_MAX);
      end else begin
        scale_r <= quo;
      end
    end

    if (cmd.mul1) begin
      m1x_r <= M1W'($signed({1'b0, scale_r})) * M1W'(bx_r);
      m1y_r <= M1W'($signed({1'b0, scale_r})) * M1W'(by_r);
    end
    if (cmd.mul2) begin
      m2x_r <= M2W'(m1x_r) * M2W'($signed({1'b0, overhang}));
      m2y_r <= M2W'(m1y_r) * M2W'($signed({1'b0, overhang}));
    end
    if (cmd.push) begin
      res_r.x <= push_axis(pc.x, m2x_r);
      res_r.y <= push_axis(pc.y, m2y_r);
    end

    if (cmd.out_load) begin
      out_data_r.ox           <= emit_x;
      out_data_r.oy           <= emit_y;
      out_data_r.oz           <= height;
      out_data_r.vertex_index <= idx_c;
      out_data_r.run_end      <= (cmd.job == pmo_pkg::J_PASS_CUR) ||
                                 (cmd.job == pmo_pkg::J_OFF_C);
    end
  end

  always_comb begin
    sts.cnt_case  = (count_r == '0) ? pmo_pkg::CNT_ZERO :
                    (count_r == CW'(1)) ? pmo_pkg::CNT_ONE : pmo_pkg::CNT_MANY;
    sts.fin       = fin_r;
    sts.vec_zero  = (mx_r == '0) && (my_r == '0);
    sts.near_zero = (sum_x <= VW'(pmo_pkg::NEAR_ZERO)) &&
                    (sum_x >= -VW'(pmo_pkg::NEAR_ZERO)) &&
                    (sum_y <= VW'(pmo_pkg::NEAR_ZERO)) &&
                    (sum_y >= -VW'(pmo_pkg::NEAR_ZERO));
    sts.sqrt_busy = sqrt_busy;
    sts.div_busy  = div_busy;
    sts.out_free  = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/pmo_ctrl.sv]
`include "polygon_miter_offset_macros.svh"

module pmo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output pmo_pkg::dp_cmd_t  cmd,
  input  pmo_pkg::dp_sts_t  sts
);
  pmo_pkg::ctrl_state_t state_r, state_nxt;
  pmo_pkg::job_t        job_r, job_nxt, job_c;
  pmo_pkg::uv_t         uv_r, uv_nxt;
  logic [1:0]           j_r, j_nxt;

  // Results owed for this transaction, by vertex count and final flag.
  always_comb begin
    job_c = pmo_pkg::J_NONE;
    case (sts.cnt_case)
      pmo_pkg::CNT_ZERO: begin
        if (sts.fin && j_r == 2'd0) job_c = pmo_pkg::J_PASS_CUR;
      end
      pmo_pkg::CNT_ONE: begin
        if (sts.fin && j_r == 2'd0) job_c = pmo_pkg::J_PASS_FIRST;
        if (sts.fin && j_r == 2'd1) job_c = pmo_pkg::J_PASS_CUR;
      end
      default: begin
        if (j_r == 2'd0) job_c = pmo_pkg::J_OFF_A;
        if (sts.fin && j_r == 2'd1) job_c = pmo_pkg::J_OFF_B;
        if (sts.fin && j_r == 2'd2) job_c = pmo_pkg::J_OFF_C;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    uv_nxt    = uv_r;
    j_nxt     = j_r;
    case (state_r)
      pmo_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pmo_pkg::S_PLAN;
          j_nxt     = 2'd0;
        end
      end
      pmo_pkg::S_PLAN: begin
        job_nxt = job_c;
        if (job_c == pmo_pkg::J_NONE) begin
          state_nxt = pmo_pkg::S_FINISH;
        end else if (job_c inside {pmo_pkg::J_PASS_CUR, pmo_pkg::J_PASS_FIRST}) begin
          state_nxt = pmo_pkg::S_EMIT;
        end else begin
          uv_nxt    = pmo_pkg::UV_IN;
          state_nxt = pmo_pkg::S_UV_LD;
        end
      end
      pmo_pkg::S_UV_LD:   state_nxt = pmo_pkg::S_UV_SQ;
      pmo_pkg::S_UV_SQ, pmo_pkg::S_DY_WAIT: begin
        if ((state_r == pmo_pkg::S_UV_SQ && sts.vec_zero) ||
            (state_r == pmo_pkg::S_DY_WAIT && !sts.div_busy)) begin
          case (uv_r)
            pmo_pkg::UV_IN: begin
              uv_nxt    = pmo_pkg::UV_OUT;
              state_nxt = pmo_pkg::S_UV_LD;
            end
            pmo_pkg::UV_OUT: state_nxt = pmo_pkg::S_SUM;
            default:         state_nxt = pmo_pkg::S_DOT1;
          endcase
        end else if (state_r == pmo_pkg::S_UV_SQ) begin
          state_nxt = pmo_pkg::S_SQ_GO;
        end
      end
      pmo_pkg::S_SQ_GO:   state_nxt = pmo_pkg::S_SQ_WAIT;
      pmo_pkg::S_SQ_WAIT: if (!sts.sqrt_busy) state_nxt = pmo_pkg::S_DX_GO;
      pmo_pkg::S_DX_GO:   state_nxt = pmo_pkg::S_DX_WAIT;
      pmo_pkg::S_DX_WAIT: if (!sts.div_busy) state_nxt = pmo_pkg::S_DY_GO;
      pmo_pkg::S_DY_GO:   state_nxt = pmo_pkg::S_DY_WAIT;
      pmo_pkg::S_SUM: begin
        if (sts.near_zero) begin
          state_nxt = pmo_pkg::S_MUL1;
        end else begin
          uv_nxt    = pmo_pkg::UV_BIS;
          state_nxt = pmo_pkg::S_UV_LD;
        end
      end
      pmo_pkg::S_DOT1:    state_nxt = pmo_pkg::S_DOT2;
      pmo_pkg::S_DOT2:    state_nxt = pmo_pkg::S_SC_GO;
      pmo_pkg::S_SC_GO:   state_nxt = pmo_pkg::S_SC_WAIT;
      pmo_pkg::S_SC_WAIT: if (!sts.div_busy) state_nxt = pmo_pkg::S_MUL1;
      pmo_pkg::S_MUL1:    state_nxt = pmo_pkg::S_MUL2;
      pmo_pkg::S_MUL2:    state_nxt = pmo_pkg::S_PUSH;
      pmo_pkg::S_PUSH:    state_nxt = pmo_pkg::S_EMIT;
      pmo_pkg::S_EMIT: begin
        if (sts.out_free) begin
          j_nxt     = j_r + 2'd1;
          state_nxt = pmo_pkg::S_PLAN;
        end
      end
      pmo_pkg::S_FINISH:  state_nxt = pmo_pkg::S_IDLE;
      default:            state_nxt = pmo_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    cmd.job    = job_r;
    cmd.uv     = uv_r;
    cmd.div_op = pmo_pkg::DIV_X;
    case (state_r)
      pmo_pkg::S_IDLE:    cmd.accept = in_valid;
      pmo_pkg::S_UV_LD:   cmd.uv_load = 1'b1;
      pmo_pkg::S_UV_SQ: begin
        cmd.uv_zero = sts.vec_zero;
        cmd.sq_load = !sts.vec_zero;
      end
      pmo_pkg::S_SQ_GO:   cmd.sqrt_start = 1'b1;
      pmo_pkg::S_DX_GO:   cmd.div_start = 1'b1;
      pmo_pkg::S_DX_WAIT: cmd.store_qx = !sts.div_busy;
      pmo_pkg::S_DY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = pmo_pkg::DIV_Y;
      end
      pmo_pkg::S_DY_WAIT: cmd.store_qy = !sts.div_busy;
      pmo_pkg::S_SUM:     cmd.bis_fallback = sts.near_zero;
      pmo_pkg::S_DOT1:    cmd.dot_load = 1'b1;
      pmo_pkg::S_DOT2:    cmd.cos_load = 1'b1;
      pmo_pkg::S_SC_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = pmo_pkg::DIV_SCALE;
      end
      pmo_pkg::S_SC_WAIT: cmd.scale_store = !sts.div_busy;
      pmo_pkg::S_MUL1:    cmd.mul1 = 1'b1;
      pmo_pkg::S_MUL2:    cmd.mul2 = 1'b1;
      pmo_pkg::S_PUSH:    cmd.push = 1'b1;
      pmo_pkg::S_EMIT:    cmd.out_load = sts.out_free;
      pmo_pkg::S_FINISH:  cmd.finish = 1'b1;
      default:            cmd.finish = 1'b0;
    endcase
  end

  assign in_stall = (state_r != pmo_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmo_pkg::S_IDLE;
      job_r   <= pmo_pkg::J_NONE;
      uv_r    <= pmo_pkg::UV_IN;
      j_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      uv_r    <= uv_nxt;
      j_r     <= j_nxt;
    end
  end

  `PMO_ASSERT_IMPL(a_sqrt_idle, clk, rst_n, cmd.sqrt_start, !sts.sqrt_busy, "sqrt restarted while busy")
  `PMO_ASSERT_NEXT(a_sqrt_runs, clk, rst_n, cmd.sqrt_start, sts.sqrt_busy, "sqrt did not launch")
  `PMO_ASSERT_IMPL(a_div_idle, clk, rst_n, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `PMO_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.out_load, sts.out_free, "result overwrote a held transaction")

endmodule

[design/polygon_miter_offset.sv]
// Miter-join offset of a counter-clockwise closed polygon.
// Input channel (in_valid/in_stall/in_data): one vertex per transaction, with
// final_vertex set on the last vertex. in_stall is high while an item is in work.
// Result channel (out_valid/out_stall/out_data): offset vertices 1..n-2 appear as
// their successor arrives; on the final vertex, vertex n-1 and then vertex 0
// follow, the latter with run_end set. Polygons of one or two vertices pass through.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is overhang,
// index 1 is height; cfg_ready is always high. Write only while idle.
// Per offset vertex, work runs from acceptance to out_valid through up to three
// unit-vector passes (each a wait on the shared square-root unit and two waits on
// the shared 18-step divider), the scale division and the setup, multiply and
// emit steps. An item also passes the accept, plan and finish states, and the
// final vertex carries three offset results.
// A pass-through result is loaded in the emit state after the plan state.
// A held result waits in the output register while the next item is taken;
// when out_stall is high the block finishes its work and waits to emit.
// Synchronous active-low reset clears the vertex count, both config registers
// and out_valid.
module polygon_miter_offset #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pmo_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pmo_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmo_pkg::CFG_W-1:0]         cfg_data
);
  logic [pmo_pkg::OVH_W-1:0] overhang_r;
  pmo_pkg::coord_t           height_r;
  pmo_pkg::dp_cmd_t          cmd;
  pmo_pkg::dp_sts_t          sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overhang_r <= '0;
      height_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pmo_pkg::REG_OVERHANG) begin
        overhang_r <= cfg_data[pmo_pkg::OVH_W-1:0];
      end else if (cfg_index == pmo_pkg::REG_HEIGHT) begin
        height_r <= cfg_data[pmo_pkg::HEIGHT_W-1:0];
      end
    end
  end

  pmo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  pmo_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .overhang  (overhang_r),
    .height    (height_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

class miter_scoreboard;
  longint unsigned     overhang;
  logic [23:0]         height;
  longint              p0x, p0y, p1x, p1y, pox, poy, pnx, pny;
  int                  vcount;
  pmo_pkg::out_item_t  pending[$];
  bit                  failed;

  function new();
    overhang = 0;
    height   = '0;
    p0x = 0; p0y = 0; p1x = 0; p1y = 0;
    pox = 0; poy = 0; pnx = 0; pny = 0;
    vcount   = 0;
    failed   = 0;
  endfunction

  function longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function longint round_shift(longint v, int s);
    longint m;
    m = (absval(v) + (64'sd1 <<< (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Q1.15 unit vector; returns 0 for the zero vector.
  function bit unit_dir(longint x, longint y, output longint ux, output longint uy);
    longint unsigned mx, my, sq, len, qx, qy;
    mx = absval(x);
    my = absval(y);
    if (mx == 0 && my == 0) begin
      ux = 0;
      uy = 0;
      return 0;
    end
    while (mx >= (64'd1 << 24) || my >= (64'd1 << 24)) begin
      mx = mx >> 1;
      my = my >> 1;
    end
    sq  = mx * mx + my * my;
    len = floor_sqrt(sq << 14);
    qx  = ((mx << 22) + len / 2) / len;
    qy  = ((my << 22) + len / 2) / len;
    if (qx > pmo_pkg::Q15_ONE) qx = pmo_pkg::Q15_ONE;
    if (qy > pmo_pkg::Q15_ONE) qy = pmo_pkg::Q15_ONE;
    ux = x < 0 ? -longint'(qx) : longint'(qx);
    uy = y < 0 ? -longint'(qy) : longint'(qy);
    return 1;
  endfunction

  function longint clamp_coord(longint v);
    return v > pmo_pkg::COORD_MAX ? pmo_pkg::COORD_MAX :
           (v < pmo_pkg::COORD_MIN ? pmo_pkg::COORD_MIN : v);
  endfunction

  function void miter(longint ax, longint ay, longint cx, longint cy,
                      longint nx, longint ny, output longint rx, output longint ry);
    longint inx, iny, onx, ony, sx, sy, bx, by, scale, c, num;
    bit in_ok, out_ok;
    in_ok  = unit_dir(cy - ay, ax - cx, inx, iny);
    out_ok = unit_dir(ny - cy, cx - nx, onx, ony);
    sx = inx + onx;
    sy = iny + ony;
    if (absval(sx) <= pmo_pkg::NEAR_ZERO && absval(sy) <= pmo_pkg::NEAR_ZERO) begin
      scale = pmo_pkg::Q15_ONE;
      bx = in_ok ? inx : onx;
      by = in_ok ? iny : ony;
    end else begin
      void'(unit_dir(sx, sy, bx, by));
      c = round_shift(bx * inx + by * iny, 15);
      if (c < pmo_pkg::COS_FLOOR) c = pmo_pkg::COS_FLOOR;
      num = 64'sd1 <<< 30;
      scale = num / c + (((num % c) * 2 >= c) ? 1 : 0);
      if (scale < pmo_pkg::Q15_ONE) scale = pmo_pkg::Q15_ONE;
      if (scale > pmo_pkg::SCALE_MAX) scale = pmo_pkg::SCALE_MAX;
    end
    rx = clamp_coord(cx + round_shift(longint'(overhang) * scale * bx, 30));
    ry = clamp_coord(cy + round_shift(longint'(overhang) * scale * by, 30));
  endfunction

  function void push_result(longint x, longint y, int idx, bit last);
    pmo_pkg::out_item_t r;
    logic [63:0] xv, yv;
    xv = x;
    yv = y;
    r.ox = xv[23:0];
    r.oy = yv[23:0];
    r.oz = height;
    r.vertex_index = (idx > 1023) ? 10'd1023 : idx[9:0];
    r.run_end = last;
    pending.push_back(r);
  endfunction

  function void note_vertex(pmo_pkg::in_item_t it);
    longint x, y, rx, ry;
    x = it.vx;
    y = it.vy;
    if (vcount == 0) begin
      p0x = x; p0y = y;
      if (it.final_vertex) push_result(x, y, 0, 1);
      else vcount = 1;
    end else if (vcount == 1) begin
      p1x = x; p1y = y;
      if (it.final_vertex) begin
        push_result(p0x, p0y, 0, 0);
        push_result(x, y, 1, 1);
        vcount = 0;
      end else begin
        pox = p0x; poy = p0y; pnx = x; pny = y;
        vcount = 2;
      end
    end else begin
      miter(pox, poy, pnx, pny, x, y, rx, ry);
      push_result(rx, ry, vcount - 1, 0);
      if (it.final_vertex) begin
        miter(pnx, pny, x, y, p0x, p0y, rx, ry);
        push_result(rx, ry, vcount, 0);
        miter(x, y, p0x, p0y, p1x, p1y, rx, ry);
        push_result(rx, ry, 0, 1);
        vcount = 0;
      end else begin
        pox = pnx; poy = pny; pnx = x; pny = y;
        if (vcount < 1024) vcount = vcount + 1;
      end
    end
  endfunction

  function void check_result(pmo_pkg::out_item_t got);
    pmo_pkg::out_item_t exp_r;
    if (pending.size() == 0) begin
      $error("unexpected result ox=%0d oy=%0d", got.ox, got.oy);
      failed = 1;
      return;
    end
    exp_r = pending.pop_front();
    if (got.ox !== exp_r.ox) begin
      $error("ox expected %0d actual %0d", exp_r.ox, got.ox); failed = 1;
    end
    if (got.oy !== exp_r.oy) begin
      $error("oy expected %0d actual %0d", exp_r.oy, got.oy); failed = 1;
    end
    if (got.oz !== exp_r.oz) begin
      $error("oz expected %0d actual %0d", exp_r.oz, got.oz); failed = 1;
    end
    if (got.vertex_index !== exp_r.vertex_index) begin
      $error("vertex_index expected %0d actual %0d", exp_r.vertex_index,
             got.vertex_index);
      failed = 1;
    end
    if (got.run_end !== exp_r.run_end) begin
      $error("run_end expected %0d actual %0d", exp_r.run_end, got.run_end); failed = 1;
    end
  endfunction
endclass

module tb_top;
  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  pmo_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  pmo_pkg::out_item_t            out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pmo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pmo_pkg::CFG_W-1:0]     cfg_data;

  miter_scoreboard sb;
  int  burst_left;
  int  hold_left;
  bit  hold_req;
  int  stall_pct;
  int  pat_left;
  longint px[$];
  longint py[$];

  polygon_miter_offset dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 0;
  always #6 clk = ~clk;

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: random stall density that changes now and then, plus a long hold.
  initial begin
    out_stall = 0;
    hold_left = 0;
    stall_pct = 0;
    pat_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = 3000;
      end
      if (pat_left == 0) begin
        pat_left = $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pat_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_vertex(longint x, longint y, bit fin);
    pmo_pkg::in_item_t it;
    logic [63:0] xv, yv;
    int gap;
    xv = x;
    yv = y;
    it.vx = xv[23:0];
    it.vy = yv[23:0];
    it.final_vertex = fin;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_vertex(it);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_polygon();
    for (int i = 0; i < px.size(); i++) send_vertex(px[i], py[i], i == px.size() - 1);
    px.delete();
    py.delete();
  endtask

  task automatic add_pt(longint x, longint y);
    px.push_back(x);
    py.push_back(y);
  endtask

  // Hold off until every expected result has come, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [pmo_pkg::CFG_IDX_W-1:0] idx,
                           logic [pmo_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pmo_pkg::REG_OVERHANG) sb.overhang = val[15:0];
    else sb.height = val;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_polygon();
    int n, style;
    longint cx, cy, r;
    longint dirx[8] = '{2, 1, 0, -1, -2, -1, 0, 1};
    longint diry[8] = '{0, 1, 2, 1, 0, -1, -2, -1};
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
    style = $urandom_range(0, 3);
    cx = $signed($urandom_range(0, 2000000)) - 1000000;
    cy = $signed($urandom_range(0, 2000000)) - 1000000;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: add_pt(longint'($signed($urandom() & 32'h00FF_FFFF) <<< 8) >>> 8,
                  longint'($signed($urandom() & 32'h00FF_FFFF) <<< 8) >>> 8);
        1: begin
          // counter-clockwise, corners taken in order from 8 directions, each with its own radius
          r = $urandom_range(1, 300000);
          add_pt(cx + dirx[(i * 8) / n] * r, cy + diry[(i * 8) / n] * r);
        end
        2: begin
          // points close together, some repeated
          if (i > 0 && $urandom_range(0, 3) == 0) add_pt(px[i - 1], py[i - 1]);
          else add_pt(cx + $urandom_range(0, 4096), cy + $urandom_range(0, 4096));
        end
        default: add_pt(cx + $signed($urandom_range(0, 200000)) - 100000,
                        cy + $signed($urandom_range(0, 200000)) - 100000);
      endcase
    end
    send_polygon();
  endtask

  initial begin
    sb = new();
    rst_n      = 0;
    in_valid   = 0;
    in_data    = '0;
    cfg_valid  = 0;
    cfg_index  = pmo_pkg::REG_OVERHANG;
    cfg_data   = '0;
    burst_left = 0;
    hold_req   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset configuration, pass-through shapes and a square
    add_pt(100, 200); send_polygon();
    add_pt(-8388608, 8388607); add_pt(8388607, -8388608); send_polygon();
    add_pt(0, 0); add_pt(2560, 0); add_pt(2560, 2560); add_pt(0, 2560); send_polygon();
    drain();

    write_reg(pmo_pkg::REG_OVERHANG, 24'd65535);
    write_reg(pmo_pkg::REG_HEIGHT, 24'h7FFFFF);
    add_pt(-8388608, -8388608); add_pt(8388607, -8388608); add_pt(0, 8388607);
    send_polygon();
    // zero-length edge
    add_pt(0, 0); add_pt(0, 0); add_pt(1000, 0); add_pt(1000, 1000); send_polygon();
    drain();

    write_reg(pmo_pkg::REG_OVERHANG, 24'd512);
    write_reg(pmo_pkg::REG_HEIGHT, 24'h800000);
    // doubling back: the bisector vanishes
    add_pt(0, 0); add_pt(1000, 0); add_pt(0, 0); send_polygon();
    // sharp spike hits the cosine floor
    add_pt(0, 0); add_pt(100000, 1); add_pt(0, 2); add_pt(-5, 1); send_polygon();
    // all points equal: no valid normal
    add_pt(7, 7); add_pt(7, 7); add_pt(7, 7); send_polygon();
    drain();

    // Random phases with varying settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_reg(pmo_pkg::REG_OVERHANG, 24'd0);
        1: write_reg(pmo_pkg::REG_OVERHANG, 24'd65535);
        default: write_reg(pmo_pkg::REG_OVERHANG, 24'($urandom_range(0, 65535)));
      endcase
      write_reg(pmo_pkg::REG_HEIGHT, 24'($urandom()));
      if (ph == 3) hold_req = 1;
      for (int k = 0; k < 6; k++) random_polygon();
      drain();
    end

    if (!sb.failed) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
